### sv/sca_pkg.sv
package sca_pkg;

  localparam int NUM_CLASSES = 41;
  localparam int MAX_SLABS   = 256;
  localparam int SLAB_BYTES  = 1048576;
  localparam int MAX_CHUNKS  = 16384;

  localparam int SLAB_AW  = 8;   // slab index bits
  localparam int WORD_AW  = 8;   // used-bit word index bits: log2(MAX_CHUNKS / 64)
  localparam int CHUNK_AW = SLAB_AW + WORD_AW;
  localparam int SZ_W     = 21;  // holds SLAB_BYTES
  localparam int CLS_W    = 6;
  localparam int CNT_W    = 9;   // slab count, 0..MAX_SLABS
  localparam int N_W      = 15;  // chunks per slab, 0..MAX_CHUNKS
  localparam int IDX_W    = 14;
  localparam int ADDR_W   = 28;
  localparam int REQ_W    = 20;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_SIZE  = 2'd1,
    ST_NO_MEM    = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_e;

  typedef enum logic [4:0] {
    S_CLR, S_IDLE,
    S_A_CLS, S_A_NDIV, S_A_SRD, S_A_SCHK, S_A_WRD, S_A_WCHK,
    S_A_RRD, S_A_RCHK, S_A_FIN,
    S_F_RD, S_F_CHK, S_F_DST, S_F_DIV1, S_F_DIV2, S_F_WRD, S_F_WCHK,
    S_DONE
  } state_e;

  typedef struct packed {
    logic             free_avail;
    logic [CLS_W-1:0] cls;
  } slab_ent_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  function automatic logic [NUM_CLASSES-1:0][SZ_W-1:0] gen_sizes();
    logic [NUM_CLASSES-1:0][SZ_W-1:0] t;
    int p;
    p = 80;
    for (int k = 0; k < NUM_CLASSES; k++) begin
      t[k] = SZ_W'(p);
      p = p + p / 4;
      if ((p & 7) > 4) p = p + 8 - (p & 7);
      else p = p - (p & 7);
    end
    return t;
  endfunction

  localparam logic [NUM_CLASSES-1:0][SZ_W-1:0] CLASS_SIZE = gen_sizes();

endpackage

### sv/sca_ram.sv
module sca_ram import sca_pkg::*; #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### sv/sca_div.sv
module sca_div import sca_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [SZ_W-1:0] dividend_i,
  input  logic [SZ_W-1:0] divisor_i,
  output div_stat_t       stat_o,
  output logic [SZ_W-1:0] quot_o,
  output logic [SZ_W-1:0] rem_o
);

  localparam int CW = $clog2(SZ_W);
  localparam logic [CW-1:0] LAST = CW'(SZ_W - 1);

  logic [SZ_W-1:0] rem_q, rem_d, quo_q, quo_d, dvs_q;
  logic [CW-1:0]   cnt_q, cnt_d;
  logic            busy_q, busy_d, done_q, done_d;
  logic [SZ_W:0]   t, diff;
  logic            ge;

  // restoring division, one quotient bit per cycle
  always_comb begin
    t      = {rem_q, quo_q[SZ_W-1]};
    diff   = t - {1'b0, dvs_q};
    ge     = t >= {1'b0, dvs_q};
    rem_d  = rem_q;
    quo_d  = quo_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d  = '0;
      quo_d  = dividend_i;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = ge ? diff[SZ_W-1:0] : t[SZ_W-1:0];
      quo_d = {quo_q[SZ_W-2:0], ge};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == LAST) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    if (start_i) dvs_q <= divisor_i;
  end

  assign stat_o = '{busy: busy_q, done: done_q};
  assign quot_o = quo_q;
  assign rem_o  = rem_q;

  property p_no_restart;
    @(posedge clk_i) disable iff (!rst_ni) busy_q |-> !start_i;
  endproperty
  a_no_restart: assert property (p_no_restart) else $error("divider restarted while busy");

endmodule

### sv/slab_chunk_allocator.sv
// channel  | dir | handshake            | payload
// s_axis   | in  | tvalid/tready        | tdata: request_bytes, free_address; tuser: cmd
// m_axis   | out | tvalid/tready        | tdata: chunk_address; tuser: status
// apb      | in  | psel/penable/pready  | reg 0 slab_limit at byte 0
//
// after reset a clearing pass zeroes all 65536 used-bit words and loads the
// slab table; no word is accepted during it
// allocate: a class search, a chunk-count division, then a scan of slabs and of used-bit
// words, all through registered-read memories with one read and one write port
// free: two passes through the shared divider
// one word at a time; the next word is taken while a result waits on m_axis
module slab_chunk_allocator import sca_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [47:0] s_axis_tdata_i,  // [19:0] request_bytes, [47:20] free_address
  input  logic        s_axis_tuser_i,  // [0] cmd
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o,  // [27:0] chunk_address, [31:28] zero
  output logic [1:0]  m_axis_tuser_o,  // [1:0] status
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  state_e state_q, state_d;

  // config register
  logic [CNT_W-1:0] limit_q;
  logic [CNT_W-1:0] lim;
  assign pready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) limit_q <= CNT_W'(41);
    else if (psel && penable && pwrite && !paddr[2]) limit_q <= pwdata[CNT_W-1:0];
  end
  assign prdata = paddr[2] ? '0 : {{(32 - CNT_W){1'b0}}, limit_q};
  assign lim    = (limit_q > CNT_W'(MAX_SLABS)) ? CNT_W'(MAX_SLABS) : limit_q;

  // working registers
  logic              cmd_q, cmd_d;
  logic [REQ_W-1:0]  req_q, req_d;
  logic [ADDR_W-1:0] fad_q, fad_d;
  logic [CLS_W-1:0]  cls_q, cls_d;
  logic [N_W-1:0]    n_q, n_d;
  logic [CNT_W-1:0]  slab_q, slab_d, cnt_q, cnt_d, word_q, word_d;
  logic [SZ_W-1:0]   idx_q, idx_d;
  logic              has_q, has_d;
  status_e           st_q, st_d;
  logic [ADDR_W-1:0] prod_q, prod_d;
  logic [CHUNK_AW:0] clr_q, clr_d;

  logic              mv_q, mv_d;
  logic [ADDR_W-1:0] mad_q, mad_d;
  status_e           mst_q, mst_d;

  // memories
  logic                chk_we, slb_we;
  logic [CHUNK_AW-1:0] chk_wa, chk_ra;
  logic [63:0]         chk_wd, chk_rd;
  logic [SLAB_AW-1:0]  slb_wa, slb_ra;
  slab_ent_t           slb_wd, slb_rd;

  sca_ram #(.WIDTH(64), .DEPTH(MAX_SLABS * MAX_CHUNKS / 64)) u_used (
    .clk_i, .we_i(chk_we), .waddr_i(chk_wa), .wdata_i(chk_wd),
    .raddr_i(chk_ra), .rdata_o(chk_rd)
  );

  sca_ram #(.WIDTH($bits(slab_ent_t)), .DEPTH(MAX_SLABS)) u_slab (
    .clk_i, .we_i(slb_we), .waddr_i(slb_wa), .wdata_i(slb_wd),
    .raddr_i(slb_ra), .rdata_o(slb_rd)
  );

  // shared divider
  logic            div_start;
  logic [SZ_W-1:0] div_a, div_b, div_q, div_r;
  div_stat_t       div_st;

  sca_div u_div (
    .clk_i, .rst_ni, .start_i(div_start), .dividend_i(div_a), .divisor_i(div_b),
    .stat_o(div_st), .quot_o(div_q), .rem_o(div_r)
  );

  logic [SZ_W-1:0] sz;
  assign sz    = (cls_q < CLS_W'(NUM_CLASSES)) ? CLASS_SIZE[cls_q] : SZ_W'(1);
  assign div_b = sz;
  assign div_a = (state_q == S_F_DST) ? {1'b0, fad_q[19:0]} : SZ_W'(SLAB_BYTES);

  // chunk count clipped to the per-slab maximum
  logic [N_W-1:0] nclip;
  assign nclip = (div_q > SZ_W'(MAX_CHUNKS)) ? N_W'(MAX_CHUNKS) : div_q[N_W-1:0];

  // valid-bit mask and first free bit of the word being looked at
  logic [CNT_W-1:0] nw;
  logic [63:0]      vmask, freeb, oneb;
  logic [5:0]       ffs;
  logic             last_w;
  assign nw     = CNT_W'((n_q + N_W'(63)) >> 6);
  assign last_w = (word_q + 1'b1) >= nw;
  always_comb begin
    if (!last_w || n_q[5:0] == 6'd0) vmask = '1;
    else vmask = (64'd1 << n_q[5:0]) - 64'd1;
    freeb = ~chk_rd & vmask;
    ffs   = '0;
    for (int b = 63; b >= 0; b--) begin
      if (freeb[b]) ffs = 6'(b);
    end
    oneb = 64'd1 << ffs;
  end

  logic in_acc;
  assign s_axis_tready_o = (state_q == S_IDLE);
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;

  always_comb begin
    state_d = state_q;
    cmd_d = cmd_q; req_d = req_q; fad_d = fad_q; cls_d = cls_q; n_d = n_q;
    slab_d = slab_q; cnt_d = cnt_q; word_d = word_q; idx_d = idx_q;
    has_d = has_q; st_d = st_q; prod_d = prod_q; clr_d = clr_q;
    mv_d = mv_q; mad_d = mad_q; mst_d = mst_q;
    chk_we = 1'b0; chk_wa = {slab_q[SLAB_AW-1:0], word_q[WORD_AW-1:0]}; chk_wd = '0;
    chk_ra = {slab_q[SLAB_AW-1:0], word_q[WORD_AW-1:0]};
    slb_we = 1'b0; slb_wa = slab_q[SLAB_AW-1:0];
    slb_wd = '{free_avail: 1'b1, cls: cls_q};
    slb_ra = slab_q[SLAB_AW-1:0];
    div_start = 1'b0;

    if (mv_q && m_axis_tready_i) mv_d = 1'b0;

    case (state_q)
      S_CLR: begin
        // sweep used bits to zero, load slab table on the way
        chk_we = 1'b1;
        chk_wa = clr_q[CHUNK_AW-1:0];
        chk_wd = '0;
        if (clr_q < (CHUNK_AW + 1)'(MAX_SLABS)) begin
          slb_we = 1'b1;
          slb_wa = clr_q[SLAB_AW-1:0];
          slb_wd = '{free_avail: 1'b1,
                     cls: (clr_q < (CHUNK_AW + 1)'(NUM_CLASSES)) ? clr_q[CLS_W-1:0] : '0};
        end
        clr_d = clr_q + 1'b1;
        if (clr_q[CHUNK_AW-1:0] == '1) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_acc) begin
          cmd_d = s_axis_tuser_i;
          req_d = s_axis_tdata_i[19:0];
          fad_d = s_axis_tdata_i[47:20];
          cls_d = '0;
          slab_d = {1'b0, s_axis_tdata_i[47:40]};
          if (s_axis_tuser_i) state_d = S_F_RD;
          else if (s_axis_tdata_i[19:0] == '0) begin
            st_d = ST_BAD_SIZE;
            state_d = S_DONE;
          end else state_d = S_A_CLS;
        end
      end
      S_A_CLS: begin
        if (cls_q >= CLS_W'(NUM_CLASSES)) begin
          st_d = ST_BAD_SIZE;
          state_d = S_DONE;
        end else if (sz >= SZ_W'(req_q)) begin
          if (sz > SZ_W'(SLAB_BYTES)) begin
            st_d = ST_BAD_SIZE;
            state_d = S_DONE;
          end else begin
            div_start = 1'b1;
            state_d = S_A_NDIV;
          end
        end else cls_d = cls_q + 1'b1;
      end
      S_A_NDIV: begin
        if (div_st.done) begin
          n_d = nclip;
          slab_d = '0;
          state_d = S_A_SRD;
        end
      end
      S_A_SRD: begin
        word_d = '0;
        if (slab_q >= cnt_q) begin
          if (cnt_q >= lim) begin
            st_d = ST_NO_MEM;
            state_d = S_DONE;
          end else begin
            // open a new slab; its used bits are still zero from the clearing pass
            slb_we = 1'b1;
            cnt_d = cnt_q + 1'b1;
            state_d = S_A_WRD;
          end
        end else state_d = S_A_SCHK;
      end
      S_A_SCHK: begin
        if (slb_rd.cls == cls_q && slb_rd.free_avail) state_d = S_A_WRD;
        else begin
          slab_d = slab_q + 1'b1;
          state_d = S_A_SRD;
        end
      end
      S_A_WRD: state_d = S_A_WCHK;
      S_A_WCHK: begin
        if (freeb != '0) begin
          idx_d = SZ_W'({word_q[WORD_AW-1:0], ffs});
          chk_we = 1'b1;
          chk_wd = chk_rd | oneb;
          if ((freeb & ~oneb) != '0) begin
            has_d = 1'b1;
            state_d = S_A_FIN;
          end else if (last_w) begin
            has_d = 1'b0;
            state_d = S_A_FIN;
          end else begin
            word_d = word_q + 1'b1;
            state_d = S_A_RRD;
          end
        end else if (last_w) begin
          slb_we = 1'b1;
          slb_wd = '{free_avail: 1'b0, cls: cls_q};
          st_d = ST_NO_MEM;
          state_d = S_DONE;
        end else begin
          word_d = word_q + 1'b1;
          state_d = S_A_WRD;
        end
      end
      // look for any free chunk left after the one just taken
      S_A_RRD: state_d = S_A_RCHK;
      S_A_RCHK: begin
        if (freeb != '0) begin
          has_d = 1'b1;
          state_d = S_A_FIN;
        end else if (last_w) begin
          has_d = 1'b0;
          state_d = S_A_FIN;
        end else begin
          word_d = word_q + 1'b1;
          state_d = S_A_RRD;
        end
      end
      S_A_FIN: begin
        slb_we = 1'b1;
        slb_wd = '{free_avail: has_q, cls: cls_q};
        prod_d = ADDR_W'(idx_q[IDX_W-1:0] * sz);
        st_d = ST_OK;
        state_d = S_DONE;
      end
      S_F_RD: begin
        if (slab_q >= cnt_q) begin
          st_d = ST_NOT_FOUND;
          state_d = S_DONE;
        end else state_d = S_F_CHK;
      end
      S_F_CHK: begin
        cls_d = slb_rd.cls;
        if (slb_rd.cls >= CLS_W'(NUM_CLASSES)) begin
          st_d = ST_NOT_FOUND;
          state_d = S_DONE;
        end else state_d = S_F_DST;
      end
      S_F_DST: begin
        div_start = 1'b1;
        state_d = S_F_DIV1;
      end
      S_F_DIV1: begin
        if (div_st.done) begin
          idx_d = div_q;
          if (div_r != '0) begin
            st_d = ST_NOT_FOUND;
            state_d = S_DONE;
          end else begin
            div_start = 1'b1;
            state_d = S_F_DIV2;
          end
        end
      end
      S_F_DIV2: begin
        if (div_st.done) begin
          if (idx_q >= SZ_W'(nclip)) begin
            st_d = ST_NOT_FOUND;
            state_d = S_DONE;
          end else begin
            word_d = CNT_W'(idx_q[IDX_W-1:6]);
            state_d = S_F_WRD;
          end
        end
      end
      S_F_WRD: state_d = S_F_WCHK;
      S_F_WCHK: begin
        if (!chk_rd[idx_q[5:0]]) st_d = ST_NOT_FOUND;
        else begin
          chk_we = 1'b1;
          chk_wd = chk_rd & ~(64'd1 << idx_q[5:0]);
          slb_we = 1'b1;
          st_d = ST_OK;
        end
        state_d = S_DONE;
      end
      S_DONE: begin
        if (!mv_q || m_axis_tready_i) begin
          mv_d = 1'b1;
          mst_d = st_q;
          mad_d = (st_q == ST_OK && !cmd_q) ?
                  ({slab_q[SLAB_AW-1:0], 20'd0} + prod_q) : '0;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR;
      cnt_q   <= CNT_W'(NUM_CLASSES);
      clr_q   <= '0;
      mv_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      clr_q   <= clr_d;
      mv_q    <= mv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d; req_q <= req_d; fad_q <= fad_d; cls_q <= cls_d; n_q <= n_d;
    slab_q <= slab_d; word_q <= word_d; idx_q <= idx_d; has_q <= has_d;
    st_q <= st_d; prod_q <= prod_d; mad_q <= mad_d; mst_q <= mst_d;
  end

  assign m_axis_tvalid_o = mv_q;
  assign m_axis_tdata_o  = {4'd0, mad_q};
  assign m_axis_tuser_o  = mst_q;

  property p_cnt_bound;
    @(posedge clk_i) disable iff (!rst_ni) cnt_q <= CNT_W'(MAX_SLABS);
  endproperty
  a_cnt_bound: assert property (p_cnt_bound) else $error("slab count past maximum");

  property p_cnt_mono;
    @(posedge clk_i) disable iff (!rst_ni) cnt_q >= $past(cnt_q);
  endproperty
  a_cnt_mono: assert property (p_cnt_mono) else $error("slab count went down");

  property p_busy_after_accept;
    @(posedge clk_i) disable iff (!rst_ni) in_acc |=> state_q != S_IDLE;
  endproperty
  a_busy_after_accept: assert property (p_busy_after_accept)
    else $error("idle right after accepting a word");

endmodule

### tb/sca_checker.sv
`timescale 1ns / 1ps

module sca_checker import sca_pkg::*; #(
  parameter logic [2:0] LIMIT_ADDR = 3'd0
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  input  logic        s_axis_tready_i,
  input  logic [47:0] s_axis_tdata_i,
  input  logic        s_axis_tuser_i,
  input  logic        m_axis_tvalid_i,
  input  logic        m_axis_tready_i,
  input  logic [31:0] m_axis_tdata_i,
  input  logic [1:0]  m_axis_tuser_i,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          fail_count_o,
  output int          pending_o
);

  typedef struct {
    logic [ADDR_W-1:0] addr;
    status_e           st;
  } alloc_result_t;

  longint unsigned  class_bytes [NUM_CLASSES];
  logic [CLS_W-1:0] slab_class  [MAX_SLABS];
  bit               slab_room   [MAX_SLABS];
  logic [MAX_CHUNKS-1:0] used_map [MAX_SLABS];
  int unsigned      open_slabs;
  int unsigned      pool_limit;
  alloc_result_t    expected_q [$];

  assign pending_o = expected_q.size();

  function automatic longint unsigned chunks_in(int unsigned c);
    longint unsigned n;
    n = SLAB_BYTES / class_bytes[c];
    return (n > MAX_CHUNKS) ? MAX_CHUNKS : n;
  endfunction

  function automatic longint unsigned lowest_free(int unsigned s, longint unsigned n);
    longint unsigned i;
    for (i = 0; i < n; i++)
      if (!used_map[s][i]) return i;
    return n;
  endfunction

  function automatic void clear_state();
    longint unsigned p;
    p = 80;
    for (int k = 0; k < NUM_CLASSES; k++) begin
      class_bytes[k] = p;
      p = p + p / 4;
      // round to a multiple of 8, remainder above 4 rounds up
      if ((p & 7) > 4) p = p + 8 - (p & 7);
      else p = p - (p & 7);
    end
    open_slabs = (NUM_CLASSES < MAX_SLABS) ? NUM_CLASSES : MAX_SLABS;
    for (int s = 0; s < MAX_SLABS; s++) begin
      slab_class[s] = (s < open_slabs) ? CLS_W'(s) : '0;
      slab_room[s]  = 1'b1;
      used_map[s]   = '0;
    end
    pool_limit = 41;
  endfunction

  function automatic void predict_alloc(logic [REQ_W-1:0] req, output alloc_result_t r);
    int unsigned c, s, lim;
    longint unsigned n, i;
    r.addr = '0;
    r.st   = ST_OK;
    if (req == 0) begin
      r.st = ST_BAD_SIZE;
      return;
    end
    for (c = 0; c < NUM_CLASSES; c++)
      if (class_bytes[c] >= req) break;
    if (c >= NUM_CLASSES || class_bytes[c] > SLAB_BYTES) begin
      r.st = ST_BAD_SIZE;
      return;
    end
    for (s = 0; s < open_slabs; s++)
      if (slab_class[s] == c && slab_room[s]) break;
    if (s >= open_slabs) begin
      lim = (pool_limit < MAX_SLABS) ? pool_limit : MAX_SLABS;
      if (open_slabs >= lim) begin
        r.st = ST_NO_MEM;
        return;
      end
      s = open_slabs;
      slab_class[s] = CLS_W'(c);
      slab_room[s]  = 1'b1;
      used_map[s]   = '0;
      open_slabs++;
    end
    n = chunks_in(c);
    i = lowest_free(s, n);
    if (i >= n) begin
      slab_room[s] = 1'b0;
      r.st = ST_NO_MEM;
      return;
    end
    used_map[s][i] = 1'b1;
    slab_room[s] = lowest_free(s, n) < n;
    r.addr = ADDR_W'(longint'(s) * SLAB_BYTES + i * class_bytes[c]);
  endfunction

  function automatic void predict_free(logic [ADDR_W-1:0] fa, output alloc_result_t r);
    int unsigned s;
    longint unsigned off, sz, idx;
    s   = fa / SLAB_BYTES;
    off = fa % SLAB_BYTES;
    r.addr = '0;
    r.st   = ST_NOT_FOUND;
    if (s >= open_slabs || slab_class[s] >= NUM_CLASSES) return;
    sz = class_bytes[slab_class[s]];
    if (off % sz != 0) return;
    idx = off / sz;
    if (idx >= chunks_in(slab_class[s]) || !used_map[s][idx]) return;
    used_map[s][idx] = 1'b0;
    slab_room[s] = 1'b1;
    r.st = ST_OK;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    alloc_result_t r, e;
    if (!rst_ni) begin
      clear_state();
      expected_q.delete();
      fail_count_o <= 0;
    end else begin
      if (psel && penable && pwrite && pready && paddr == LIMIT_ADDR)
        pool_limit = pwdata[8:0];
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        if (s_axis_tuser_i) predict_free(s_axis_tdata_i[47:20], r);
        else predict_alloc(s_axis_tdata_i[19:0], r);
        expected_q.push_back(r);
      end
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        if (expected_q.size() == 0) begin
          $error("unexpected word: chunk_address %h status %0d",
                 m_axis_tdata_i[27:0], m_axis_tuser_i);
          fail_count_o <= fail_count_o + 1;
        end else begin
          e = expected_q.pop_front();
          if (m_axis_tdata_i[27:0] !== e.addr || m_axis_tuser_i !== e.st) begin
            if (m_axis_tdata_i[27:0] !== e.addr)
              $error("chunk_address: expected %h actual %h", e.addr, m_axis_tdata_i[27:0]);
            if (m_axis_tuser_i !== e.st)
              $error("status: expected %0d actual %0d", e.st, m_axis_tuser_i);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
    end
  end

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import sca_pkg::*;

  localparam logic [2:0] LIMIT_ADDR = 3'd0;  // slab_limit register
  localparam bit CMD_ALLOC = 1'b0;
  localparam bit CMD_FREE  = 1'b1;
  localparam int RANDOM_WORDS = 600;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [47:0] s_tdata = '0;    // [19:0] request_bytes, [47:20] free_address
  logic        s_tuser = 1'b0;  // [0] cmd
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;         // [27:0] chunk_address, [31:28] zero
  logic [1:0]  m_tuser;         // [1:0] status
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  int fail_count;
  int pending;
  bit steady = 1'b0;  // no idling on either side while set

  // commands in flight, matched against returned words to learn live chunks
  bit              cmd_in_flight [$];
  logic [ADDR_W-1:0] live_chunks [$];

  always #1 clk_i = ~clk_i;

  slab_chunk_allocator DUT (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .s_axis_tvalid_i(s_tvalid), .s_axis_tready_o(s_tready),
    .s_axis_tdata_i(s_tdata), .s_axis_tuser_i(s_tuser),
    .m_axis_tvalid_o(m_tvalid), .m_axis_tready_i(m_tready),
    .m_axis_tdata_o(m_tdata), .m_axis_tuser_o(m_tuser),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  sca_checker #(.LIMIT_ADDR(LIMIT_ADDR)) u_checker (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .s_axis_tvalid_i(s_tvalid), .s_axis_tready_i(s_tready),
    .s_axis_tdata_i(s_tdata), .s_axis_tuser_i(s_tuser),
    .m_axis_tvalid_i(m_tvalid), .m_axis_tready_i(m_tready),
    .m_axis_tdata_i(m_tdata), .m_axis_tuser_i(m_tuser),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .pready(pready),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  // result side stalls at random
  always @(posedge clk_i) m_tready <= steady || ($urandom_range(99) >= 19);

  // track which allocations succeeded so frees can target real chunks
  always @(posedge clk_i) begin
    bit was_free;
    if (s_tvalid && s_tready) cmd_in_flight.push_back(s_tuser);
    if (m_tvalid && m_tready && cmd_in_flight.size() != 0) begin
      was_free = cmd_in_flight.pop_front();
      if (!was_free && m_tuser == ST_OK) live_chunks.push_back(m_tdata[27:0]);
    end
  end

  // valid stays high from one word to the next unless a gap is taken
  task automatic send_word(bit cmd, logic [REQ_W-1:0] req, logic [ADDR_W-1:0] fa);
    if (!steady && $urandom_range(99) < 19) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= {fa, req};
    @(posedge clk_i);
    while (!s_tready) @(posedge clk_i);
  endtask

  task automatic wait_drained();
    @(posedge clk_i);
    s_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_limit(logic [8:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= LIMIT_ADDR;
    pwdata  <= {23'd0, v};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // size that lands in class k; callers bias k toward the big classes so slabs fill up
  function automatic logic [REQ_W-1:0] size_for_class(int k);
    if (k == 0) return REQ_W'($urandom_range(1, CLASS_SIZE[0]));
    return REQ_W'($urandom_range(CLASS_SIZE[k-1] + 1, CLASS_SIZE[k]));
  endfunction

  task automatic random_word();
    int pick, k, j;
    logic [ADDR_W-1:0] a;
    pick = $urandom_range(99);
    if (pick < 48) begin
      k = ($urandom_range(99) < 60) ? $urandom_range(28, NUM_CLASSES - 1)
                                    : $urandom_range(0, NUM_CLASSES - 1);
      send_word(CMD_ALLOC, size_for_class(k), ADDR_W'($urandom));
    end else if (pick < 85 && live_chunks.size() != 0) begin
      j = $urandom_range(live_chunks.size() - 1);
      a = live_chunks[j];
      live_chunks.delete(j);
      // sometimes a double free or a misaligned one
      if ($urandom_range(9) == 0) live_chunks.push_back(a);
      else if ($urandom_range(19) == 0) a = a + ADDR_W'(8);
      send_word(CMD_FREE, REQ_W'($urandom), a);
    end else if (pick < 93) begin
      send_word(CMD_ALLOC, REQ_W'($urandom), ADDR_W'($urandom));
    end else begin
      send_word(CMD_FREE, REQ_W'($urandom), ADDR_W'($urandom));
    end
  endtask

  initial begin
    logic [8:0] limits [4];
    limits = '{9'd256, 9'd511, 9'd60, 9'd41};
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: size edges, full pool, free corner cases
    send_word(CMD_ALLOC, 20'd0, '0);                     // zero request
    send_word(CMD_ALLOC, 20'd1, '0);                     // chunk at address zero
    send_word(CMD_ALLOC, 20'd80, '0);
    send_word(CMD_ALLOC, 20'd81, 28'hFFFFFFF);
    send_word(CMD_ALLOC, 20'd573760, '0);                // largest class, one chunk slab
    send_word(CMD_ALLOC, 20'd573760, '0);                // pool full at default limit
    send_word(CMD_ALLOC, 20'd573761, '0);                // above largest class
    send_word(CMD_ALLOC, 20'hFFFFF, '0);
    send_word(CMD_FREE, 20'hFFFFF, 28'd0);               // address zero is valid
    send_word(CMD_FREE, '0, 28'd0);                      // now not in use
    send_word(CMD_FREE, '0, 28'd1);                      // misaligned
    send_word(CMD_FREE, '0, 28'hFFFFFFF);                // slab not open
    send_word(CMD_FREE, '0, ADDR_W'(40 * SLAB_BYTES + 573760));  // slack past last chunk
    send_word(CMD_FREE, '0, ADDR_W'(40 * SLAB_BYTES));   // largest-class chunk
    send_word(CMD_ALLOC, 20'd573760, '0);                // space restored by the free
    wait_drained();

    // random phases, each under a different pool limit
    for (int ph = 0; ph < 4; ph++) begin
      write_limit(limits[ph]);
      for (int n = 0; n < RANDOM_WORDS / 4; n++) begin
        steady <= (ph == 1 && n >= 40 && n < 120);
        random_word();
      end
      steady <= 1'b0;
      wait_drained();
    end

    if (fail_count == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("tb: failure");
    $finish;
  end

endmodule
